FILE: hdl/vtbt_pkg.sv
// Shared types, constants and helpers of the volume table block translator.
package vtbt_pkg;

    localparam int unsigned SECTORS_PER_CYLINDER = 64;
    localparam int unsigned VOLUME_SLOTS         = 8;
    localparam int unsigned CYLINDERS            = 1024;

    localparam int unsigned SLOT_W   = (VOLUME_SLOTS > 1) ? $clog2(VOLUME_SLOTS) : 1;
    localparam int unsigned DISK_W   = $clog2(CYLINDERS * SECTORS_PER_CYLINDER + 1);
    localparam int unsigned LIN_W    = ((DISK_W > 18) ? DISK_W : 18) + 1;
    localparam logic [LIN_W-1:0] DISK_SECTORS = LIN_W'(CYLINDERS * SECTORS_PER_CYLINDER);

    // request kinds
    localparam logic [1:0] K_CREATE    = 2'd0;
    localparam logic [1:0] K_DELETE    = 2'd1;
    localparam logic [1:0] K_TRANSLATE = 2'd2;

    // volume types
    localparam logic [1:0] VT_NONE = 2'd0;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_OVERLAP = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_NOVOL   = 3'd4;
    localparam logic [2:0] ST_RANGE   = 3'd5;

    // request held steady for the whole pass along the chain
    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       vol;
        logic [LIN_W-1:0] lin_s;
        logic [LIN_W-1:0] lin_e;
        logic [15:0]      blk;
    } t_req;

    // token that walks the chain, gathering the answer
    typedef struct packed {
        logic              valid;
        logic              overlap;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic              hit;
        logic              range_bad;
        logic [9:0]        ocyl;
        logic [5:0]        osec;
    } t_tok;

    // table write broadcast at the end of a successful create
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [9:0]        cyl;
        logic [5:0]        sec;
        logic [16:0]       len;
        logic [1:0]        vtype;
    } t_wr;

    function automatic logic [LIN_W-1:0] lin_addr(input logic [9:0] cyl,
                                                  input logic [5:0] sec);
        lin_addr = LIN_W'(LIN_W'(cyl) * LIN_W'(SECTORS_PER_CYLINDER)) + LIN_W'(sec);
    endfunction

endpackage

FILE: hdl/vtbt_cell.sv
// One table cell: holds a volume entry and refines the passing token.
module vtbt_cell
    import vtbt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  t_req              i_req,
    input  t_wr               i_wr,
    input  t_tok              i_tok,
    output t_tok              o_tok
);

    logic [9:0]       r_cyl;
    logic [5:0]       r_sec;
    logic [16:0]      r_len;
    logic [1:0]       r_type;
    t_tok             r_tok;
    t_tok             n_tok;
    logic [LIN_W-1:0] w_vs;
    logic [LIN_W-1:0] w_ve;
    logic [16:0]      w_lin;
    logic             w_match;
    logic             w_used;

    assign w_vs    = lin_addr(r_cyl, r_sec);
    assign w_ve    = w_vs + LIN_W'(r_len);
    assign w_lin   = 17'(r_sec) + 17'(i_req.blk);
    assign w_match = (32'(i_req.vol) == 32'(i_idx));
    assign w_used  = (r_type != VT_NONE);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            case (i_req.kind)
                K_CREATE: begin
                    if (w_used && (i_req.lin_s < w_ve) && (w_vs < i_req.lin_e)) begin
                        n_tok.overlap = 1'b1;
                    end
                    if (!w_used && !i_tok.free_found) begin
                        n_tok.free_found = 1'b1;
                        n_tok.free_slot  = i_idx;
                    end
                end
                K_TRANSLATE: begin
                    if (w_match && w_used) begin
                        n_tok.hit       = 1'b1;
                        n_tok.range_bad = (17'(i_req.blk) >= r_len);
                        n_tok.ocyl      = 10'(32'(r_cyl) + (w_lin / SECTORS_PER_CYLINDER));
                        n_tok.osec      = 6'(w_lin % SECTORS_PER_CYLINDER);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type      <= VT_NONE;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && (i_wr.slot == i_idx)) begin
                r_type <= i_wr.vtype;
            end else if (i_tok.valid && (i_req.kind == K_DELETE) && w_match) begin
                r_type <= VT_NONE;
            end
        end
    end

    // entry payload needs no reset: it is only read while the type is in use
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.slot == i_idx)) begin
            r_cyl <= i_wr.cyl;
            r_sec <= i_wr.sec;
            r_len <= i_wr.len;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: hdl/volume_table_block_translator_core.sv
// Top level of the volume table block translator: request control and cell chain.
//
// Usage
//   Input channel: i_valid / o_stall with fields i_kind, i_volume, i_start_cylinder,
//   i_start_sector, i_length, i_volume_type and i_block. A transaction is taken at
//   a rising edge where i_valid is high and o_stall is low.
//   Output channel: o_valid / i_stall with o_status, o_slot, o_cylinder, o_sector.
//   Every input transaction yields exactly one output transaction.
//   Timing: a request walks a token through one cell per table slot, one cell a
//   cycle; its result is registered first in a pending result stage and then in
//   the output register that drives o_valid. One request is in flight at a time;
//   the next is taken once the previous result has left the pending stage.
//   Creates commit to the table in the cycle the token leaves the last cell.
//   Reset (synchronous, active low) empties every slot and drops any pending work.
//   A stalled receiver holds the output register; the block then finishes the
//   request in flight, holds its result, and stalls the input until it drains.
module volume_table_block_translator_core
    import vtbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_volume,
    input  logic [9:0]  i_start_cylinder,
    input  logic [5:0]  i_start_sector,
    input  logic [16:0] i_length,
    input  logic [1:0]  i_volume_type,
    input  logic [15:0] i_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot,
    output logic [9:0]  o_cylinder,
    output logic [5:0]  o_sector
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_POST = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic              r_launch;
    t_req              r_req;
    logic              r_bad;
    logic [9:0]        r_cyl;
    logic [5:0]        r_sec;
    logic [16:0]       r_len;
    logic [1:0]        r_type;
    logic [2:0]        r_res_status;
    logic [2:0]        r_res_slot;
    logic [9:0]        r_res_cyl;
    logic [5:0]        r_res_sec;
    logic              r_out_valid;
    logic [2:0]        r_out_status;
    logic [2:0]        r_out_slot;
    logic [9:0]        r_out_cyl;
    logic [5:0]        r_out_sec;

    logic              w_in_acc;
    logic              w_out_load;
    logic [LIN_W-1:0]  w_s;
    logic [LIN_W-1:0]  w_e;
    logic              w_bad;
    t_tok              w_tok [0:VOLUME_SLOTS];
    logic [VOLUME_SLOTS:0] w_tok_valid;
    t_tok              w_last;
    logic              w_exit;
    logic              w_vol_out;
    logic [2:0]        n_status;
    logic [2:0]        n_slot;
    logic [9:0]        n_cyl;
    logic [5:0]        n_sec;
    t_wr               w_wr;

    // Accept only between requests; the result stage is decoupled below.
    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;

    // Create sanity checks on the raw request, registered with it.
    assign w_s   = lin_addr(i_start_cylinder, i_start_sector);
    assign w_e   = w_s + LIN_W'(i_length);
    assign w_bad = (i_volume_type == VT_NONE)
                || ((i_start_cylinder == 10'd0) && (i_start_sector == 6'd0))
                || (32'(i_start_sector) >= SECTORS_PER_CYLINDER)
                || (i_length == 17'd0)
                || (w_e > DISK_SECTORS);

    // Launch token: a fresh, empty answer entering the first cell.
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = r_launch;
    end

    genvar g;
    generate
        for (g = 0; g < VOLUME_SLOTS; g++) begin : g_cell
            vtbt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (SLOT_W'(g)),
                .i_req   (r_req),
                .i_wr    (w_wr),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
        for (g = 0; g <= VOLUME_SLOTS; g++) begin : g_valid
            assign w_tok_valid[g] = w_tok[g].valid;
        end
    endgenerate

    assign w_last    = w_tok[VOLUME_SLOTS];
    assign w_exit    = w_last.valid && (r_state == S_RUN);
    assign w_vol_out = (32'(r_req.vol) >= VOLUME_SLOTS);

    // Resolve the answer once the token leaves the last cell.
    always_comb begin
        n_status = ST_BAD;
        n_slot   = 3'd0;
        n_cyl    = 10'd0;
        n_sec    = 6'd0;
        case (r_req.kind)
            K_CREATE: begin
                if (r_bad) begin
                    n_status = ST_BAD;
                end else if (w_last.overlap) begin
                    n_status = ST_OVERLAP;
                end else if (!w_last.free_found) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_slot   = 3'(w_last.free_slot);
                end
            end
            K_DELETE: begin
                n_status = w_vol_out ? ST_NOVOL : ST_OK;
            end
            K_TRANSLATE: begin
                if (w_vol_out || !w_last.hit) begin
                    n_status = ST_NOVOL;
                end else if (w_last.range_bad) begin
                    n_status = ST_RANGE;
                end else begin
                    n_status = ST_OK;
                    n_cyl    = w_last.ocyl;
                    n_sec    = w_last.osec;
                end
            end
            default: begin
                n_status = ST_BAD;
            end
        endcase
    end

    // Commit a successful create into the first free slot.
    always_comb begin
        w_wr.en    = w_exit && (r_req.kind == K_CREATE) && !r_bad
                     && !w_last.overlap && w_last.free_found;
        w_wr.slot  = w_last.free_slot;
        w_wr.cyl   = r_cyl;
        w_wr.sec   = r_sec;
        w_wr.len   = r_len;
        w_wr.vtype = r_type;
    end

    assign w_out_load = (r_state == S_POST) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_RUN;
            S_RUN:  if (w_exit) n_state = S_POST;
            S_POST: if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_in_acc;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request for the pass; capture the answer; load the output.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req.kind  <= i_kind;
            r_req.vol   <= i_volume;
            r_req.lin_s <= w_s;
            r_req.lin_e <= w_e;
            r_req.blk   <= i_block;
            r_bad       <= w_bad;
            r_cyl       <= i_start_cylinder;
            r_sec       <= i_start_sector;
            r_len       <= i_length;
            r_type      <= i_volume_type;
        end
        if (w_exit) begin
            r_res_status <= n_status;
            r_res_slot   <= n_slot;
            r_res_cyl    <= n_cyl;
            r_res_sec    <= n_sec;
        end
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_cyl    <= r_res_cyl;
            r_out_sec    <= r_res_sec;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_slot     = r_out_slot;
    assign o_cylinder = r_out_cyl;
    assign o_sector   = r_out_sec;

`ifndef SYNTHESIS
    a_token_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> ##(VOLUME_SLOTS + 1) w_last.valid)
        else $error("token did not leave the chain on time");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one token in the chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_tok_valid == '0))
        else $error("token in the chain while idle");

    a_commit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |=> (r_state == S_POST))
        else $error("table write outside the end of a pass");
`endif

endmodule
